/* rtl/core/ymcbp_pkg.sv */
package ymcbp_pkg;

  // Defaults for the top-level parameters
  localparam int ROW_PIXELS_DEF  = 672;
  localparam int COLOUR_BITS_DEF = 6;
  localparam int MAX_ROWS_DEF    = 1016;

  // Fixed storage limits
  localparam int PLANES_MAX = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 10;
  localparam int ROW_SAT    = 1023;
  localparam int COFF_W     = 19;
  localparam int KOFF_W     = 17;

  // Group queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Channel slots inside a plane
  localparam int CH_Y = 0;
  localparam int CH_M = 1;
  localparam int CH_C = 2;

  typedef logic [PLANES_MAX-1:0][2:0][7:0] plane_set_t;

  typedef struct packed {
    logic [7:0] yellow_in;
    logic [7:0] magenta_in;
    logic [7:0] cyan_in;
    logic       end_of_image;
  } in_item_t;

  typedef struct packed {
    logic [2:0]        bit_index;
    logic [7:0]        yellow_byte;
    logic [7:0]        magenta_byte;
    logic [7:0]        cyan_byte;
    logic [COFF_W-1:0] colour_offset;
    logic [7:0]        black_byte;
    logic [KOFF_W-1:0] black_offset;
    logic              black_valid;
    logic              last_in_group;
    logic              image_done;
    logic              row_overflow;
  } out_item_t;

  // One finished byte group, as handed from front to back
  typedef struct packed {
    plane_set_t        planes;
    logic [7:0]        black_byte;
    logic [COFF_W-1:0] colour_base;
    logic [KOFF_W-1:0] black_offset;
    logic              black_en;
    logic              eoi;
    logic              ovf;
  } grp_rec_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

/* rtl/core/ymc_bitplane_packer.sv */
// Y/M/C bit-plane packer.
// Input channel (in_valid/in_stall/in_data): one pixel per beat, three 8-bit
// samples and an end-of-image flag. Each sample is cut to COLOUR_BITS bits;
// with cfg black extraction on, a pixel full in all three becomes a K dot.
// Output channel (out_valid/out_stall/out_data): after each eighth pixel, the
// last pixel of a row or the final pixel, a run of COLOUR_BITS results, one
// per plane, bit 0 first, each with its packed bytes and byte offsets.
// Configuration: cfg_wr_en/cfg_wr_data write the extraction enable; write it
// only while the block is idle.
// Throughput: one pixel per cycle in, one result per cycle out while out_stall
// is low. Finished byte groups wait in a four-entry queue; the front stalls
// the input only when that queue is full, i.e. when runs arrive faster than
// the result port drains them, one result per plane, as with short groups at
// row or image end. The pixel that closes a group writes its record into the
// queue; the back end then registers each result of the run for output.
// Reset (rst_n, synchronous): counts, accumulators and the enable clear, the
// queue empties and out_valid drops. A stalled result holds until taken.
module ymc_bitplane_packer #(
  parameter int ROW_PIXELS  = ymcbp_pkg::ROW_PIXELS_DEF,
  parameter int COLOUR_BITS = ymcbp_pkg::COLOUR_BITS_DEF,
  parameter int MAX_ROWS    = ymcbp_pkg::MAX_ROWS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  ymcbp_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ymcbp_pkg::out_item_t out_data
);

  logic                push;
  logic                pop;
  ymcbp_pkg::grp_rec_t push_data;
  ymcbp_pkg::grp_rec_t head;
  ymcbp_pkg::q_stat_t  q_stat;

  ymcbp_front #(
    .ROW_PIXELS  (ROW_PIXELS),
    .COLOUR_BITS (COLOUR_BITS),
    .MAX_ROWS    (MAX_ROWS)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .q_stat      (q_stat),
    .push        (push),
    .push_data   (push_data)
  );

  ymcbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .rd_data   (head),
    .q_stat    (q_stat)
  );

  ymcbp_back #(
    .ROW_PIXELS  (ROW_PIXELS),
    .COLOUR_BITS (COLOUR_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

/* rtl/core/ymcbp_front.sv */
module ymcbp_front #(
  parameter int ROW_PIXELS  = ymcbp_pkg::ROW_PIXELS_DEF,
  parameter int COLOUR_BITS = ymcbp_pkg::COLOUR_BITS_DEF,
  parameter int MAX_ROWS    = ymcbp_pkg::MAX_ROWS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  logic                in_valid,
  output logic                in_stall,
  input  ymcbp_pkg::in_item_t in_data,
  input  ymcbp_pkg::q_stat_t  q_stat,
  output logic                push,
  output ymcbp_pkg::grp_rec_t push_data
);

  localparam int BPR = (ROW_PIXELS + 7) / 8;
  localparam logic [7:0] FULL_VAL = 8'((1 << COLOUR_BITS) - 1);

  logic                              blk_en_r;
  logic [ymcbp_pkg::COL_W-1:0]       col_r, col_nxt;
  logic [ymcbp_pkg::ROW_W-1:0]       row_r, row_nxt;
  ymcbp_pkg::plane_set_t             acc_r, acc_nxt;
  logic [7:0]                        kacc_r, kacc_nxt;

  logic                              accept;
  logic [2:0][7:0]                   v;
  logic                              kdot;
  logic [7:0]                        mask;
  logic                              grp_start;
  logic                              last_col;
  logic                              flush;
  logic                              ovf;
  logic [ymcbp_pkg::ROW_W-1:0]       row_eff;
  logic [6:0]                        byte_pos;
  logic [31:0]                       cbase_full;
  logic [31:0]                       kbase_full;

  // Extraction enable register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blk_en_r <= 1'b0;
    end else if (cfg_wr_en) begin
      blk_en_r <= cfg_wr_data;
    end
  end

  assign accept   = in_valid && !q_stat.full;
  assign in_stall = q_stat.full;

  // Reduce samples and pick out true black
  always_comb begin
    v[ymcbp_pkg::CH_Y] = in_data.yellow_in  >> (8 - COLOUR_BITS);
    v[ymcbp_pkg::CH_M] = in_data.magenta_in >> (8 - COLOUR_BITS);
    v[ymcbp_pkg::CH_C] = in_data.cyan_in    >> (8 - COLOUR_BITS);
    kdot = blk_en_r && v[ymcbp_pkg::CH_Y] == FULL_VAL &&
           v[ymcbp_pkg::CH_M] == FULL_VAL && v[ymcbp_pkg::CH_C] == FULL_VAL;
    if (kdot) begin
      v = '0;
    end
  end

  assign mask      = 8'h80 >> col_r[2:0];
  assign grp_start = (col_r[2:0] == 3'd0);
  assign last_col  = ({1'b0, col_r} + 11'd1) >= 11'(ROW_PIXELS);
  assign flush     = (col_r[2:0] == 3'd7) || last_col || in_data.end_of_image;

  // Merge the pixel into the plane accumulators, clearing at group start
  always_comb begin
    for (int j = 0; j < ymcbp_pkg::PLANES_MAX; j++) begin
      for (int c = 0; c < 3; c++) begin
        if (j < COLOUR_BITS) begin
          acc_nxt[j][c] = (grp_start ? 8'd0 : acc_r[j][c]) | (v[c][j] ? mask : 8'd0);
        end else begin
          acc_nxt[j][c] = 8'd0;
        end
      end
    end
    kacc_nxt = (grp_start ? 8'd0 : kacc_r) | (kdot ? mask : 8'd0);
  end

  // Row and byte offsets, saturated past the last row
  assign ovf        = {1'b0, row_r} >= 11'(MAX_ROWS);
  assign row_eff    = ovf ? ymcbp_pkg::ROW_W'(MAX_ROWS - 1) : row_r;
  assign byte_pos   = col_r[ymcbp_pkg::COL_W-1:3];
  assign cbase_full = 32'(row_eff) * 32'(BPR * COLOUR_BITS) + 32'(byte_pos);
  assign kbase_full = 32'(row_eff) * 32'(BPR) + 32'(byte_pos);

  always_comb begin
    push_data.planes       = acc_nxt;
    push_data.black_byte   = kacc_nxt;
    push_data.colour_base  = cbase_full[ymcbp_pkg::COFF_W-1:0];
    push_data.black_offset = kbase_full[ymcbp_pkg::KOFF_W-1:0];
    push_data.black_en     = blk_en_r;
    push_data.eoi          = in_data.end_of_image;
    push_data.ovf          = ovf;
  end

  assign push = accept && flush;

  // Advance column and row counts
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_data.end_of_image) begin
      col_nxt = '0;
      row_nxt = '0;
    end else if (last_col) begin
      col_nxt = '0;
      if (row_r != ymcbp_pkg::ROW_W'(ymcbp_pkg::ROW_SAT)) begin
        row_nxt = row_r + 1'b1;
      end
    end else begin
      col_nxt = col_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r  <= '0;
      row_r  <= '0;
      acc_r  <= '0;
      kacc_r <= '0;
    end else if (accept) begin
      col_r  <= col_nxt;
      row_r  <= row_nxt;
      acc_r  <= acc_nxt;
      kacc_r <= kacc_nxt;
    end
  end

endmodule

/* rtl/core/ymcbp_queue.sv */
module ymcbp_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  ymcbp_pkg::grp_rec_t push_data,
  input  logic                pop,
  output ymcbp_pkg::grp_rec_t rd_data,
  output ymcbp_pkg::q_stat_t  q_stat
);

  ymcbp_pkg::grp_rec_t               mem_r [ymcbp_pkg::QUEUE_DEPTH];
  logic [ymcbp_pkg::QPTR_W-1:0]      wr_ptr_r, rd_ptr_r;
  logic [ymcbp_pkg::QCNT_W-1:0]      cnt_r, cnt_nxt;

  // Store group records
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  assign rd_data = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_nxt;
    end
  end

  assign q_stat.full  = (cnt_r == ymcbp_pkg::QCNT_W'(ymcbp_pkg::QUEUE_DEPTH));
  assign q_stat.empty = (cnt_r == '0);

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_stat.full)
    else $error("group pushed into full queue");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !q_stat.empty)
    else $error("group popped from empty queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= ymcbp_pkg::QCNT_W'(ymcbp_pkg::QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

/* rtl/core/ymcbp_back.sv */
module ymcbp_back #(
  parameter int ROW_PIXELS  = ymcbp_pkg::ROW_PIXELS_DEF,
  parameter int COLOUR_BITS = ymcbp_pkg::COLOUR_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  ymcbp_pkg::grp_rec_t  head,
  input  ymcbp_pkg::q_stat_t   q_stat,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output ymcbp_pkg::out_item_t out_data
);

  localparam int BPR = (ROW_PIXELS + 7) / 8;

  logic [2:0]           j_r, j_nxt;
  logic                 out_valid_r, out_valid_nxt;
  ymcbp_pkg::out_item_t out_data_r, out_data_nxt;
  logic                 issue;
  logic                 last;
  logic                 bv;
  logic [31:0]          plane_off;

  assign issue = !q_stat.empty && (!out_valid_r || !out_stall);
  assign last  = (j_r == 3'(COLOUR_BITS - 1));
  assign pop   = issue && last;
  assign bv    = (j_r == 3'd0) && head.black_en;

  assign plane_off = 32'(j_r) * 32'(BPR);

  // Build one result of the run for the current plane
  always_comb begin
    out_data_nxt.bit_index     = j_r;
    out_data_nxt.yellow_byte   = head.planes[j_r][ymcbp_pkg::CH_Y];
    out_data_nxt.magenta_byte  = head.planes[j_r][ymcbp_pkg::CH_M];
    out_data_nxt.cyan_byte     = head.planes[j_r][ymcbp_pkg::CH_C];
    out_data_nxt.colour_offset = head.colour_base + plane_off[ymcbp_pkg::COFF_W-1:0];
    out_data_nxt.black_byte    = bv ? head.black_byte : 8'd0;
    out_data_nxt.black_offset  = bv ? head.black_offset : '0;
    out_data_nxt.black_valid   = bv;
    out_data_nxt.last_in_group = last;
    out_data_nxt.image_done    = head.eoi;
    out_data_nxt.row_overflow  = head.ovf;
  end

  always_comb begin
    j_nxt = j_r;
    if (issue) begin
      j_nxt = last ? 3'd0 : j_r + 3'd1;
    end
    if (issue) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  // Hold the result until taken, step through planes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      j_r         <= j_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  a_plane_range: assert property (@(posedge clk) disable iff (!rst_n)
    j_r < 3'(COLOUR_BITS))
    else $error("plane counter out of range");

  a_black_plane0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.black_valid |-> out_data_r.bit_index == 3'd0)
    else $error("black field on a plane other than bit 0");

  a_last_marks_end: assert property (@(posedge clk) disable iff (!rst_n)
    issue && last |=> out_valid_r && out_data_r.last_in_group && j_r == 3'd0)
    else $error("run end not marked or counter not rewound");

endmodule

/* dv/ymcbp_plane_checker.sv */
module ymcbp_plane_checker (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  ymcbp_pkg::in_item_t  in_data,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  ymcbp_pkg::out_item_t out_data,
  output int                   mismatches,
  output int                   results_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PLANES       = ymcbp_pkg::COLOUR_BITS_DEF;
  localparam int ROW_LEN      = ymcbp_pkg::ROW_PIXELS_DEF;
  localparam int ROW_LIMIT    = ymcbp_pkg::MAX_ROWS_DEF;
  localparam int ROW_BYTES    = (ROW_LEN + 7) / 8;
  localparam int FULL_LEVEL   = (1 << PLANES) - 1;
  localparam int REPORT_LINES = 60;

  // Shadow of the packer state
  int         col_pos;
  int         row_pos;
  logic [7:0] plane_acc [3][PLANES];
  logic [7:0] k_acc;
  logic       black_en;

  // Result beats owed by the block, oldest first
  ymcbp_pkg::out_item_t planes_due[$];

  initial mismatches = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= REPORT_LINES) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic match_field(input string field, input int unsigned plane,
                             input int unsigned got, input int unsigned want);
    if (got != want)
      report_mismatch($sformatf("plane %0d %s got 0x%0h want 0x%0h",
                                plane, field, got, want));
  endtask

  // Fold one pixel into the byte group and queue a run when the group closes
  task automatic pack_pixel(input ymcbp_pkg::in_item_t px);
    int                   lvl [3];
    int                   pos;
    int                   sh;
    int                   r;
    logic                 kdot;
    logic                 ovf;
    logic                 first;
    ymcbp_pkg::out_item_t e;
    lvl[ymcbp_pkg::CH_Y] = int'(px.yellow_in >> (8 - PLANES));
    lvl[ymcbp_pkg::CH_M] = int'(px.magenta_in >> (8 - PLANES));
    lvl[ymcbp_pkg::CH_C] = int'(px.cyan_in >> (8 - PLANES));
    kdot = black_en && lvl[ymcbp_pkg::CH_Y] == FULL_LEVEL &&
           lvl[ymcbp_pkg::CH_M] == FULL_LEVEL && lvl[ymcbp_pkg::CH_C] == FULL_LEVEL;
    // Full black becomes a K dot with no colour
    if (kdot) lvl = '{0, 0, 0};
    pos = col_pos / 8;
    sh  = 7 - (col_pos % 8);

    // Clear the group at its first pixel
    if (sh == 7) begin
      for (int ch = 0; ch < 3; ch++)
        for (int j = 0; j < PLANES; j++) plane_acc[ch][j] = 8'h00;
      k_acc = 8'h00;
    end
    for (int ch = 0; ch < 3; ch++)
      for (int j = 0; j < PLANES; j++)
        if (lvl[ch][j]) plane_acc[ch][j][sh] = 1'b1;
    if (kdot) k_acc[sh] = 1'b1;

    // Close the group: eighth pixel, row end or image end
    if (sh == 0 || col_pos + 1 >= ROW_LEN || px.end_of_image) begin
      ovf = (row_pos >= ROW_LIMIT);
      r   = ovf ? ROW_LIMIT - 1 : row_pos;
      for (int j = 0; j < PLANES; j++) begin
        first           = (j == 0) && black_en;
        e.bit_index     = 3'(j);
        e.yellow_byte   = plane_acc[ymcbp_pkg::CH_Y][j];
        e.magenta_byte  = plane_acc[ymcbp_pkg::CH_M][j];
        e.cyan_byte     = plane_acc[ymcbp_pkg::CH_C][j];
        e.colour_offset = ymcbp_pkg::COFF_W'(r * ROW_BYTES * PLANES + j * ROW_BYTES + pos);
        e.black_byte    = first ? k_acc : 8'h00;
        e.black_offset  = first ? ymcbp_pkg::KOFF_W'(r * ROW_BYTES + pos) : '0;
        e.black_valid   = first;
        e.last_in_group = (j == PLANES - 1);
        e.image_done    = px.end_of_image;
        e.row_overflow  = ovf;
        planes_due.push_back(e);
      end
    end

    // Advance the column and row counts
    if (px.end_of_image) begin
      col_pos = 0;
      row_pos = 0;
    end else if (col_pos + 1 >= ROW_LEN) begin
      col_pos = 0;
      if (row_pos < ymcbp_pkg::ROW_SAT) row_pos++;
    end else begin
      col_pos++;
    end
  endtask

  // Compare one result beat against the oldest owed beat
  task automatic check_result(input ymcbp_pkg::out_item_t got);
    ymcbp_pkg::out_item_t want;
    if (planes_due.size() == 0) begin
      report_mismatch($sformatf("result beat for plane %0d with nothing owed",
                                got.bit_index));
      return;
    end
    want = planes_due.pop_front();
    match_field("bit_index", want.bit_index, got.bit_index, want.bit_index);
    match_field("yellow_byte", want.bit_index, got.yellow_byte, want.yellow_byte);
    match_field("magenta_byte", want.bit_index, got.magenta_byte, want.magenta_byte);
    match_field("cyan_byte", want.bit_index, got.cyan_byte, want.cyan_byte);
    match_field("colour_offset", want.bit_index, got.colour_offset,
                want.colour_offset);
    match_field("black_byte", want.bit_index, got.black_byte, want.black_byte);
    match_field("black_offset", want.bit_index, got.black_offset, want.black_offset);
    match_field("black_valid", want.bit_index, got.black_valid, want.black_valid);
    match_field("last_in_group", want.bit_index, got.last_in_group,
                want.last_in_group);
    match_field("image_done", want.bit_index, got.image_done, want.image_done);
    match_field("row_overflow", want.bit_index, got.row_overflow, want.row_overflow);
  endtask

  // Watch both channels and the register port
  always @(posedge clk) begin
    if (!rst_n) begin
      col_pos  = 0;
      row_pos  = 0;
      k_acc    = 8'h00;
      black_en = 1'b0;
      for (int ch = 0; ch < 3; ch++)
        for (int j = 0; j < PLANES; j++) plane_acc[ch][j] = 8'h00;
      planes_due.delete();
    end else begin
      if (cfg_wr_en) black_en = cfg_wr_data;
      if (out_valid && !out_stall) check_result(out_data);
      if (in_valid && !in_stall) pack_pixel(in_data);
    end
    results_pending <= planes_due.size();
  end

endmodule

/* dv/tb_ymc_bitplane_packer.sv */
module tb_ymc_bitplane_packer;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int STALL_NONE   = 0;
  localparam int STALL_RANDOM = 1;
  localparam int STALL_RUNS   = 2;
  localparam int QUIET_LIMIT  = 3000;
  localparam int HOLD_OFF     = 8;

  logic                 clk;
  logic                 rst_n       = 1'b0;
  logic                 cfg_wr_en   = 1'b0;
  logic                 cfg_wr_data = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  ymcbp_pkg::in_item_t  in_data     = '0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  ymcbp_pkg::out_item_t out_data;

  int mismatches;
  int results_pending;
  int stall_mode  = STALL_RANDOM;
  int stall_run   = 0;
  int quiet_cycles = 0;
  int burst_left  = 0;
  bit gaps_on     = 1'b1;

  ymc_bitplane_packer dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

  ymcbp_plane_checker plane_check (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_data         (in_data),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_data        (out_data),
    .mismatches      (mismatches),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result channel on its own pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else begin
      case (stall_mode)
        STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
        STALL_RUNS: begin
          if (stall_run == 0) begin
            out_stall <= ~out_stall;
            stall_run <= $urandom_range(1, 16);
          end else begin
            stall_run <= stall_run - 1;
          end
        end
        default: out_stall <= 1'b0;
      endcase
    end
  end

  // End the run if no beat moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == QUIET_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pixel beat and hold it until taken; rest between bursts
  task automatic send_pixel(input ymcbp_pkg::in_item_t px);
    int gap;
    if (gaps_on && burst_left == 0) begin
      gap = $urandom_range(1, 10);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = $urandom_range(1, 24);
    end
    in_valid <= 1'b1;
    in_data  <= px;
    do @(posedge clk); while (in_stall);
    if (burst_left > 0) burst_left--;
  endtask

  // Hold the input until every owed result has come, then let the block settle
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (HOLD_OFF) @(posedge clk);
  endtask

  task automatic write_black_enable(input logic value);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Mix of full black, near black, saturated and random pixels
  function automatic ymcbp_pkg::in_item_t random_pixel(input int eoi_pct);
    ymcbp_pkg::in_item_t px;
    int kind;
    kind          = $urandom_range(0, 9);
    px.yellow_in  = 8'($urandom);
    px.magenta_in = 8'($urandom);
    px.cyan_in    = 8'($urandom);
    case (kind)
      0, 1, 2: begin
        px.yellow_in  = 8'hfc | 8'($urandom_range(0, 3));
        px.magenta_in = 8'hfc | 8'($urandom_range(0, 3));
        px.cyan_in    = 8'hfc | 8'($urandom_range(0, 3));
        // Knock one channel below full
        if (kind == 2) begin
          case ($urandom_range(0, 2))
            0: px.yellow_in = 8'($urandom_range(0, 8'hfb));
            1: px.magenta_in = 8'($urandom_range(0, 8'hfb));
            default: px.cyan_in = 8'($urandom_range(0, 8'hfb));
          endcase
        end
      end
      3: begin
        px.yellow_in  = $urandom_range(0, 1) ? 8'hff : 8'h00;
        px.magenta_in = $urandom_range(0, 1) ? 8'hff : 8'h00;
        px.cyan_in    = $urandom_range(0, 1) ? 8'hff : 8'h00;
      end
      default: ;
    endcase
    px.end_of_image = ($urandom_range(0, 99) < eoi_pct);
    return px;
  endfunction

  task automatic random_phase(input logic enable, input int count);
    write_black_enable(enable);
    for (int i = 0; i < count; i++) begin
      // Vary idling so that some stretches run flat out
      if (i % 40 == 0) begin
        stall_mode <= $urandom_range(STALL_NONE, STALL_RUNS);
        gaps_on = $urandom_range(0, 1);
      end
      send_pixel(random_pixel(3));
    end
    drain_results();
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Extraction off: full pixels stay colour, low bits dropped
    write_black_enable(1'b0);
    send_pixel(ymcbp_pkg::in_item_t'{8'hff, 8'hff, 8'hff, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'h00, 8'h00, 8'h00, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'hfc, 8'hfc, 8'hfc, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'h03, 8'h03, 8'h03, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'h80, 8'h40, 8'h20, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'h04, 8'h08, 8'h10, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'haa, 8'h55, 8'hf0, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'h0f, 8'hc3, 8'h3c, 1'b0});
    // Partial group flushed at image end
    send_pixel(ymcbp_pkg::in_item_t'{8'hff, 8'h00, 8'h7f, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'h01, 8'hfe, 8'h80, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'h3c, 8'h3c, 8'h3c, 1'b1});
    drain_results();

    // Extraction on: K dots, near misses, image end on the eighth pixel
    write_black_enable(1'b1);
    send_pixel(ymcbp_pkg::in_item_t'{8'hff, 8'hff, 8'hff, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'hfc, 8'hfd, 8'hfe, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'hfb, 8'hff, 8'hff, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'hff, 8'hf8, 8'hff, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'h00, 8'h00, 8'h00, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'hff, 8'hff, 8'hff, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'hfe, 8'hff, 8'hfc, 1'b0});
    send_pixel(ymcbp_pkg::in_item_t'{8'h55, 8'haa, 8'hff, 1'b1});
    // Single-pixel images
    send_pixel(ymcbp_pkg::in_item_t'{8'hff, 8'hff, 8'hff, 1'b1});
    send_pixel(ymcbp_pkg::in_item_t'{8'h00, 8'h00, 8'h00, 1'b1});
    drain_results();

    // Random stream under both settings
    random_phase(1'b1, 120);
    random_phase(1'b0, 110);

    // Wait for the tail and give the verdict
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_pending != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
